// ===== rtl/core/tpcd_pkg.sv =====
// Package for the tree pseudo-LRU cache directory.
// Field widths of the item ports, operation codes and the control state type.
// No dependencies.
package tpcd_pkg;

  localparam int FUNC_W     = 1;
  localparam int SET_IDX_W  = 6;
  localparam int LINE_TAG_W = 20;
  localparam int OUT_WAY_W  = 3;

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FILL   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

endpackage

// ===== rtl/core/tree_plru_cache_directory.sv =====
// Tag directory of a set-associative cache with tree pseudo-LRU replacement.
// Holds the tag memory and the valid/tree memory with their read-modify-write control.
// Depends on tpcd_pkg.
//
//   channel | direction | ports                                     | transfer
//   --------+-----------+-------------------------------------------+------------------------
//   in      | input     | in_func, in_set_index, in_line_tag        | in_valid && !in_stall
//   out     | output    | out_hit, out_way, out_evicted             | out_valid && !out_stall
//
// An item first has its set's row read synchronously from both memories. In the
// write-back state it is compared, the tree updated and the row written back.
// The next item is taken in the cycle after the write-back, so the read always
// sees the updated row. After reset the valid/tree memory is cleared one row a
// cycle, all SETS rows, while in_stall is high. A stalled out channel holds the
// item in its write-back cycle once the output register is full.
module tree_plru_cache_directory #(
  parameter int WAYS     = 8,
  parameter int SETS     = 64,
  parameter int TAG_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tpcd_pkg::FUNC_W-1:0]         in_func,
  input  logic [tpcd_pkg::SET_IDX_W-1:0]      in_set_index,
  input  logic [tpcd_pkg::LINE_TAG_W-1:0]     in_line_tag,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output logic [tpcd_pkg::OUT_WAY_W-1:0]      out_way,
  output logic                                out_evicted
);

  localparam int WAY_W     = $clog2(WAYS);
  localparam int TREE_W    = (1 << WAY_W) - 1;
  localparam int META_W    = TREE_W + WAYS;
  localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int SET_LUT_N = 1 << tpcd_pkg::SET_IDX_W;

  // memories
  logic [WAYS-1:0][TAG_BITS-1:0] tag_mem  [SETS];
  logic [META_W-1:0]             meta_mem [SETS];

  tpcd_pkg::state_t state_r, state_nxt;
  logic [SET_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [tpcd_pkg::FUNC_W-1:0] func_r;
  logic [SET_W-1:0]            set_r;
  logic [TAG_BITS-1:0]         tag_r;

  logic [WAYS-1:0][TAG_BITS-1:0] tag_rd_r;
  logic [META_W-1:0]             meta_rd_r;

  logic                              out_valid_r, out_valid_nxt;
  logic                              out_hit_r;
  logic [tpcd_pkg::OUT_WAY_W-1:0]    out_way_r;
  logic                              out_evicted_r;

  logic [SET_W-1:0] set_lut [SET_LUT_N];
  logic [SET_W-1:0] in_set;
  logic             in_xfer, out_xfer, look_done;

  logic [WAYS-1:0]   valid_rd;
  logic [TREE_W-1:0] tree_rd;
  logic [WAYS-1:0]   match;
  logic              hit_any, inv_any;
  logic [WAY_W-1:0]  hit_way, inv_way, vic_way, wr_way;
  logic [TREE_W-1:0] tree_touched, tree_vic;

  logic                          meta_we, tag_we;
  logic [SET_W-1:0]              meta_wa;
  logic [META_W-1:0]             meta_wd;
  logic [WAYS-1:0][TAG_BITS-1:0] tag_wd;
  logic [WAYS-1:0]               valid_wd;
  logic [TREE_W-1:0]             tree_wd;
  logic                          res_hit, res_evicted;
  logic [WAY_W-1:0]              res_way;

  // set index reduction table, 2**SET_IDX_W constant entries
  for (genvar g = 0; g < SET_LUT_N; g++) begin : g_set_lut
    localparam int RED = g % SETS;
    assign set_lut[g] = SET_W'(RED);
  end

  // point every node on the path to way w away from it
  function automatic logic [TREE_W-1:0] plru_touch(input logic [TREE_W-1:0] bits,
                                                    input logic [WAY_W-1:0] w);
    logic [TREE_W-1:0] b;
    logic [WAY_W-1:0]  l, r, mid;
    logic [WAY_W:0]    sum;
    logic [WAY_W:0]    node;
    logic              dir;
    b    = bits;
    l    = '0;
    r    = WAY_W'(WAYS - 1);
    node = '0;
    for (int lv = 0; lv < WAY_W; lv++) begin
      if (r > l) begin
        sum = {1'b0, l} + {1'b0, r};
        mid = sum[WAY_W:1];
        dir = (w > mid);
        b[node[WAY_W-1:0]] = ~dir;
        if (dir) begin
          l = mid + WAY_W'(1);
        end else begin
          r = mid;
        end
        node = {node[WAY_W-1:0], 1'b0} + (WAY_W+1)'(1) + (WAY_W+1)'(dir);
      end
    end
    return b;
  endfunction

  // follow and flip the direction bits down to the victim
  function automatic void plru_victim(input  logic [TREE_W-1:0] bits,
                                      output logic [TREE_W-1:0] bits_o,
                                      output logic [WAY_W-1:0]  way_o);
    logic [TREE_W-1:0] b;
    logic [WAY_W-1:0]  l, r, mid;
    logic [WAY_W:0]    sum;
    logic [WAY_W:0]    node;
    logic              dir;
    b    = bits;
    l    = '0;
    r    = WAY_W'(WAYS - 1);
    node = '0;
    for (int lv = 0; lv < WAY_W; lv++) begin
      if (r > l) begin
        sum = {1'b0, l} + {1'b0, r};
        mid = sum[WAY_W:1];
        dir = b[node[WAY_W-1:0]];
        b[node[WAY_W-1:0]] = ~dir;
        if (dir) begin
          l = mid + WAY_W'(1);
        end else begin
          r = mid;
        end
        node = {node[WAY_W-1:0], 1'b0} + (WAY_W+1)'(1) + (WAY_W+1)'(dir);
      end
    end
    bits_o = b;
    way_o  = l;
  endfunction

  assign in_set    = set_lut[in_set_index];
  assign in_stall  = (state_r != tpcd_pkg::ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign look_done = (state_r == tpcd_pkg::ST_LOOK) && (!out_valid_r || !out_stall);

  assign valid_rd = meta_rd_r[WAYS-1:0];
  assign tree_rd  = meta_rd_r[WAYS +: TREE_W];

  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = valid_rd[w] && (tag_rd_r[w] == tag_r);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!valid_rd[w]) begin
        inv_way = WAY_W'(w);
      end
    end
    hit_any      = |match;
    inv_any      = ~&valid_rd;
    tree_touched = plru_touch(tree_rd, hit_way);
    plru_victim(tree_rd, tree_vic, vic_way);
  end

  // result and write-back data
  always_comb begin
    res_hit     = 1'b0;
    res_way     = '0;
    res_evicted = 1'b0;
    wr_way      = inv_any ? inv_way : vic_way;
    valid_wd    = valid_rd;
    tree_wd     = tree_rd;
    tag_wd      = tag_rd_r;
    tag_wd[wr_way] = tag_r;
    case (func_r)
      tpcd_pkg::FUNC_LOOKUP: begin
        res_hit = hit_any;
        res_way = hit_any ? hit_way : '0;
        tree_wd = tree_touched;
      end
      tpcd_pkg::FUNC_FILL: begin
        res_way          = wr_way;
        res_evicted      = !inv_any;
        valid_wd[wr_way] = 1'b1;
        tree_wd          = inv_any ? tree_rd : tree_vic;
      end
      default: begin
        res_hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    meta_we = 1'b0;
    meta_wa = set_r;
    meta_wd = {tree_wd, valid_wd};
    tag_we  = look_done && (func_r == tpcd_pkg::FUNC_FILL);
    if (state_r == tpcd_pkg::ST_CLEAR) begin
      meta_we = 1'b1;
      meta_wa = clr_cnt_r;
      meta_wd = '0;
    end else if (look_done) begin
      meta_we = (func_r == tpcd_pkg::FUNC_FILL) || hit_any;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      tpcd_pkg::ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + SET_W'(1);
        if (clr_cnt_r == SET_W'(SETS - 1)) begin
          state_nxt = tpcd_pkg::ST_IDLE;
        end
      end
      tpcd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = tpcd_pkg::ST_LOOK;
        end
      end
      tpcd_pkg::ST_LOOK: begin
        if (look_done) begin
          state_nxt     = tpcd_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = tpcd_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpcd_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r <= in_func;
      set_r  <= in_set;
      tag_r  <= TAG_BITS'(in_line_tag);
    end
    if (look_done) begin
      out_hit_r     <= res_hit;
      out_way_r     <= tpcd_pkg::OUT_WAY_W'(res_way);
      out_evicted_r <= res_evicted;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tag_rd_r  <= tag_mem[in_set];
      meta_rd_r <= meta_mem[in_set];
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[set_r] <= tag_wd;
    end
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_way     = out_way_r;
  assign out_evicted = out_evicted_r;

  a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == tpcd_pkg::ST_LOOK)
    else $error("accepted item did not enter write-back");

  a_hit_not_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted))
    else $error("result flags both hit and eviction");

  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tpcd_pkg::ST_CLEAR |-> in_stall && !tag_we)
    else $error("input open during clearing pass");

endmodule
